[rtl/hkit_pkg.sv]
// Shared types, sizes, codes and hash constants for the hashed key index table.
// No dependencies; every other file but hkit_ram imports this package.
package hkit_pkg;

   localparam int ENTRIES   = 256;
   localparam int MAP_SLOTS = 512;
   localparam int POS_W     = $clog2(ENTRIES);
   localparam int SLOT_W    = $clog2(MAP_SLOTS);
   localparam int COUNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W     = 64;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 3;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 24;
   localparam int HASH_LAT  = 5;

   localparam int              FMIX_SHIFT = 33;
   localparam logic [KEY_W-1:0] FMIX_C1   = 64'hff51afd7ed558ccd;
   localparam logic [KEY_W-1:0] FMIX_C2   = 64'hc4ceb9fe1a85ec53;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [KEY_W-1:0]  key_type;

   typedef struct packed {
      logic    used;
      pos_type pos;
   } map_entry_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_LK_MAP,
      S_LK_SLOT,
      S_LK_KEY,
      S_IN_MAP,
      S_IN_SLOT,
      S_RM_KEY,
      S_RM_KWAIT,
      S_FD_MAP,
      S_FD_SLOT,
      S_MV_KEY,
      S_MV_KWAIT,
      S_RM_ZERO,
      S_DONE
   } state_type;

   function automatic slot_type next_slot(input slot_type s);
      slot_type r;
      if (s == SLOT_W'(MAP_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

endpackage

[rtl/hkit_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hkit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/hkit_hash.sv]
// fmix64 finalizer as a five-stage pipeline; 64-bit products built from 32x32 parts.
// Depends on hkit_pkg.
module hkit_hash (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  hkit_pkg::key_type key,
   output logic             done,
   output hkit_pkg::slot_type slot
);
   import hkit_pkg::*;

   key_type           v1_ff, mid_ff;
   logic [63:0]       p0_ff, q0_ff;
   logic [31:0]       p1_ff, p2_ff, q1_ff, q2_ff;
   slot_type          slot_ff;
   logic [HASH_LAT-1:0] vld_ff;
   key_type           m1, m2, fin;

   assign m1  = p0_ff + {p1_ff + p2_ff, 32'b0};
   assign m2  = q0_ff + {q1_ff + q2_ff, 32'b0};
   assign fin = m2 ^ (m2 >> FMIX_SHIFT);

   always_ff @(posedge clock) begin
      v1_ff   <= key ^ (key >> FMIX_SHIFT);
      p0_ff   <= v1_ff[31:0] * FMIX_C1[31:0];
      p1_ff   <= v1_ff[63:32] * FMIX_C1[31:0];
      p2_ff   <= v1_ff[31:0] * FMIX_C1[63:32];
      mid_ff  <= m1 ^ (m1 >> FMIX_SHIFT);
      q0_ff   <= mid_ff[31:0] * FMIX_C2[31:0];
      q1_ff   <= mid_ff[63:32] * FMIX_C2[31:0];
      q2_ff   <= mid_ff[31:0] * FMIX_C2[63:32];
      slot_ff <= fin[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[HASH_LAT-2:0], start};
      end
   end

   assign done = vld_ff[HASH_LAT-1];
   assign slot = slot_ff;
endmodule

[rtl/hashed_key_index_table_unit.sv]
// Top level of the hashed key index table: control sequencer, key store and index map.
// Depends on hkit_pkg, hkit_ram and hkit_hash.
//
// Keeps up to 256 64-bit keys in a dense store and a 512-slot linearly probed
// index map hashed with fmix64. One beat is processed at a time. After reset the
// map's 512 slots are swept clear with req_tready low. A lookup or insert passes
// through accept, hash and result, plus a map read per slot probed, with a key
// read for each occupied slot a lookup probes. A remove reads the key to be
// removed, hashes it and scans the map for its position's slot; when the last
// entry is moved down, its key is read, hashed and scanned for as well. Each
// scan walks up to the whole map. The cost per probe is set by the registered
// read of the map and key memories.
module hashed_key_index_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // key [63:0], position [71:64]
   input  logic [1:0]  req_tuser,   // mode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found_position [7:0], entries_in_use [16:8], zero [23:17]
   output logic [2:0]  rsp_tuser    // status [2:0]
);
   import hkit_pkg::*;

   state_type state_ff, state_in;
   logic [MODE_W-1:0] op_ff, op_in;
   key_type   key_ff, key_in;
   pos_type   pos_ff, pos_in, mpos_ff, mpos_in, fpos_ff, fpos_in;
   slot_type  slot_ff, slot_in, home_ff, home_in, clr_ff, clr_in;
   count_type count_ff, count_in, last_ff, last_in;
   logic      phase_ff, phase_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   pos_type   rsp_fpos_ff, rsp_fpos_in;
   count_type rsp_count_ff, rsp_count_in;

   logic          req_accept, rsp_load;
   logic [MODE_W-1:0] req_mode;
   key_type       req_key;
   pos_type       req_pos;
   logic          key_we;
   pos_type       key_waddr, key_raddr;
   key_type       key_wdata, key_rdata;
   logic          map_we;
   slot_type      map_waddr, map_raddr;
   map_entry_type map_wdata, map_rdata;
   logic          hash_start, hash_done;
   key_type       hash_key;
   slot_type      hash_slot;
   slot_type      slot_nx;
   logic          probe_end, fd_match;
   pos_type       fd_target;
   count_type     count_dec;

   assign req_mode = req_tuser;
   assign req_key  = req_tdata[63:0];
   assign req_pos  = req_tdata[71:64];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign slot_nx   = next_slot(slot_ff);
   assign probe_end = (slot_nx == home_ff);
   assign fd_target = phase_ff ? last_ff[POS_W-1:0] : pos_ff;
   assign fd_match  = map_rdata.used && (map_rdata.pos == fd_target);
   assign count_dec = count_ff - 1'b1;

   hkit_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   hkit_ram #(.WIDTH($bits(map_entry_type)), .DEPTH(MAP_SLOTS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   hkit_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == SLOT_W'(MAP_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_mode)
                  MODE_LOOKUP, MODE_INSERT: state_in = S_HASH;
                  MODE_REMOVE: begin
                     if ({1'b0, req_pos} < count_ff) state_in = S_RM_KEY;
                     else                            state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_HASH: begin
            if (hash_done) begin
               unique case (op_ff)
                  MODE_LOOKUP: state_in = S_LK_MAP;
                  MODE_INSERT: state_in = S_IN_MAP;
                  default:     state_in = S_FD_MAP;
               endcase
            end
         end
         S_LK_MAP:  state_in = S_LK_SLOT;
         S_LK_SLOT: state_in = map_rdata.used ? S_LK_KEY : S_DONE;
         S_LK_KEY: begin
            if (key_rdata == key_ff || probe_end) state_in = S_DONE;
            else                                  state_in = S_LK_MAP;
         end
         S_IN_MAP:  state_in = S_IN_SLOT;
         S_IN_SLOT: begin
            if (!map_rdata.used || probe_end) state_in = S_DONE;
            else                              state_in = S_IN_MAP;
         end
         S_RM_KEY:   state_in = S_RM_KWAIT;
         S_RM_KWAIT: state_in = S_HASH;
         S_FD_MAP:   state_in = S_FD_SLOT;
         S_FD_SLOT: begin
            if (fd_match || probe_end) begin
               if (!phase_ff && ({1'b0, pos_ff} < count_dec)) state_in = S_MV_KEY;
               else                                           state_in = S_RM_ZERO;
            end else begin
               state_in = S_FD_MAP;
            end
         end
         S_MV_KEY:   state_in = S_MV_KWAIT;
         S_MV_KWAIT: state_in = S_HASH;
         S_RM_ZERO:  state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // memory and hash controls
   always_comb begin
      key_we     = 1'b0;
      key_waddr  = pos_ff;
      key_wdata  = key_rdata;
      key_raddr  = pos_ff;
      map_we     = 1'b0;
      map_waddr  = slot_ff;
      map_wdata  = '0;
      map_raddr  = slot_ff;
      hash_start = 1'b0;
      hash_key   = req_key;
      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
         end
         S_IDLE: begin
            if (req_accept && (req_mode == MODE_LOOKUP || req_mode == MODE_INSERT)) begin
               hash_start = 1'b1;
            end
            if (req_accept && req_mode == MODE_INSERT) begin
               key_we    = 1'b1;
               key_waddr = req_pos;
               key_wdata = req_key;
            end
         end
         S_LK_SLOT: key_raddr = map_rdata.pos;
         S_IN_SLOT: begin
            if (!map_rdata.used) begin
               map_we    = 1'b1;
               map_wdata = map_entry_type'{used: 1'b1, pos: pos_ff};
            end
         end
         S_RM_KWAIT: begin
            hash_start = 1'b1;
            hash_key   = key_rdata;
         end
         S_FD_SLOT: begin
            if (fd_match) begin
               map_we = 1'b1;
               // first scan frees the slot, second renames the moved entry
               map_wdata = phase_ff ? map_entry_type'{used: 1'b1, pos: pos_ff}
                                    : map_entry_type'{used: 1'b0, pos: map_rdata.pos};
            end
         end
         S_MV_KEY: key_raddr = last_ff[POS_W-1:0];
         S_MV_KWAIT: begin
            hash_start = 1'b1;
            hash_key   = key_rdata;
            key_we     = 1'b1;
            key_waddr  = pos_ff;
            key_wdata  = key_rdata;
         end
         S_RM_ZERO: begin
            key_we    = 1'b1;
            key_waddr = last_ff[POS_W-1:0];
            key_wdata = '0;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      mpos_in       = mpos_ff;
      fpos_in       = fpos_ff;
      slot_in       = slot_ff;
      home_in       = home_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      phase_in      = phase_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         S_CLEAR: clr_in = clr_ff + 1'b1;
         S_IDLE: begin
            if (req_accept) begin
               op_in     = req_mode;
               key_in    = req_key;
               pos_in    = req_pos;
               status_in = ST_IGNORED;
               fpos_in   = '0;
               phase_in  = 1'b0;
               if (req_mode == MODE_INSERT && {1'b0, req_pos} >= count_ff) begin
                  count_in = {1'b0, req_pos} + 1'b1;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               slot_in = hash_slot;
               home_in = hash_slot;
            end
         end
         S_LK_SLOT: begin
            mpos_in = map_rdata.pos;
            if (!map_rdata.used) status_in = ST_NOT_FOUND;
         end
         S_LK_KEY: begin
            if (key_rdata == key_ff) begin
               status_in = ST_FOUND;
               fpos_in   = mpos_ff;
            end else if (probe_end) begin
               status_in = ST_NOT_FOUND;
            end else begin
               slot_in = slot_nx;
            end
         end
         S_IN_SLOT: begin
            if (!map_rdata.used)  status_in = ST_INSERTED;
            else if (probe_end)   status_in = ST_FULL;
            else                  slot_in   = slot_nx;
         end
         S_FD_SLOT: begin
            if (fd_match || probe_end) begin
               if (!phase_ff) begin
                  count_in = count_dec;
                  last_in  = count_dec;
               end
            end else begin
               slot_in = slot_nx;
            end
         end
         S_MV_KWAIT: phase_in = 1'b1;
         S_RM_ZERO:  status_in = ST_REMOVED;
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_fpos_in   = fpos_ff;
               rsp_count_in  = count_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      mpos_ff       <= mpos_in;
      fpos_ff       <= fpos_in;
      slot_ff       <= slot_in;
      home_ff       <= home_in;
      last_ff       <= last_in;
      phase_ff      <= phase_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - POS_W - COUNT_W){1'b0}}, rsp_count_ff, rsp_fpos_ff};

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(ENTRIES))
      else $error("entry count beyond store depth");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (map_we && !map_wdata.used))
      else $error("clearing pass wrote a used slot");

   a_hash_owner: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("hash result arrived outside hash wait");

   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff <= ST_IGNORED))
      else $error("undefined status code on result");
`endif
endmodule

[tb/hkit_checker.sv]
// Checker for the hashed key index table: watches both streams, predicts each response.
// Depends on hkit_pkg; instantiated by the testbench top beside the unit.
module hkit_checker
   import hkit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,   // key [63:0], position [71:64]
   input  logic [1:0]  req_tuser,   // mode [1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // found_position [7:0], entries_in_use [16:8], zero [23:17]
   input  logic [2:0]  rsp_tuser,   // status [2:0]
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      pos_type             found_pos;
      count_type           in_use;
   } answer_type;

   key_type    shadow_keys [ENTRIES];
   logic       slot_used   [MAP_SLOTS];
   pos_type    slot_pos    [MAP_SLOTS];
   int         live_count;
   answer_type answers_due [$];

   function automatic key_type mix_key(input key_type k);
      key_type v;
      v = k ^ (k >> FMIX_SHIFT);
      v = v * FMIX_C1;
      v = v ^ (v >> FMIX_SHIFT);
      v = v * FMIX_C2;
      v = v ^ (v >> FMIX_SHIFT);
      return v;
   endfunction

   function automatic int home_of(input key_type k);
      key_type h;
      h = mix_key(k);
      return int'(h % MAP_SLOTS);
   endfunction

   // first used slot naming position p on k's probe path, -1 if none
   function automatic int locate_slot(input key_type k, input int p);
      int s;
      s = home_of(k);
      for (int n = 0; n < MAP_SLOTS; n++) begin
         if (slot_used[s] && int'(slot_pos[s]) == p) return s;
         s = (s == MAP_SLOTS - 1) ? 0 : s + 1;
      end
      return -1;
   endfunction

   task automatic apply_request(input logic [1:0] mode, input key_type k, input pos_type p,
                                output answer_type a);
      int s;
      int last;
      a.status    = ST_IGNORED;
      a.found_pos = '0;
      if (mode == MODE_LOOKUP) begin
         a.status = ST_NOT_FOUND;
         s = home_of(k);
         for (int n = 0; n < MAP_SLOTS; n++) begin
            if (!slot_used[s]) break;
            if (shadow_keys[slot_pos[s]] == k) begin
               a.status    = ST_FOUND;
               a.found_pos = slot_pos[s];
               break;
            end
            s = (s == MAP_SLOTS - 1) ? 0 : s + 1;
         end
      end else if (mode == MODE_INSERT) begin
         shadow_keys[p] = k;
         a.status = ST_FULL;
         s = home_of(k);
         for (int n = 0; n < MAP_SLOTS; n++) begin
            if (!slot_used[s]) begin
               slot_used[s] = 1'b1;
               slot_pos[s]  = p;
               a.status     = ST_INSERTED;
               break;
            end
            s = (s == MAP_SLOTS - 1) ? 0 : s + 1;
         end
         if (int'(p) >= live_count) live_count = int'(p) + 1;
      end else if (mode == MODE_REMOVE) begin
         if (int'(p) < live_count) begin
            s = locate_slot(shadow_keys[p], int'(p));
            if (s >= 0) slot_used[s] = 1'b0;
            live_count--;
            last = live_count;
            if (int'(p) < last) begin
               shadow_keys[p] = shadow_keys[last];
               s = locate_slot(shadow_keys[p], last);
               if (s >= 0) slot_pos[s] = p;
            end
            shadow_keys[last] = '0;
            a.status = ST_REMOVED;
         end
      end
      a.in_use = count_type'(live_count);
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      live_count = 0;
      for (int i = 0; i < MAP_SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_pos[i]  = '0;
      end
      for (int i = 0; i < ENTRIES; i++) shadow_keys[i] = '0;
   end

   assign outstanding = answers_due.size();

   always @(posedge clock) begin
      answer_type a;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[63:0], req_tdata[71:64], a);
            answers_due.push_back(a);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               report("unexpected beat, status", rsp_tuser, -1);
            end else begin
               a = answers_due.pop_front();
               if (rsp_tuser != a.status) report("status", rsp_tuser, a.status);
               if (rsp_tdata[7:0] != a.found_pos)
                  report("found_position", rsp_tdata[7:0], a.found_pos);
               if (rsp_tdata[16:8] != a.in_use)
                  report("entries_in_use", rsp_tdata[16:8], a.in_use);
            end
         end
      end
   end

endmodule

[tb/testbench.sv]
// Top of the hashed key index table bench: clock, reset, beat stimulus and verdict.
// Depends on hkit_pkg, hkit_checker and the unit under test.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hkit_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   int          mismatches;
   int          outstanding;
   int          cycles = 0;
   bit          steady = 1'b0;

   // stimulus-side view: entry count and which store entries hold a written key
   int          fill_count = 0;
   bit          written [ENTRIES];
   key_type     recent_keys [64];

   always #10 clock = ~clock;

   hashed_key_index_table_unit u_top (.*);

   hkit_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 9);
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_beat(input logic [1:0] mode, input key_type k, input pos_type p);
      bit taken;
      int last;
      while (!steady && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p, k};
      req_tuser  <= mode;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      if (mode == MODE_INSERT) begin
         written[p] = 1'b1;
         recent_keys[$urandom_range(63)] = k;
         if (int'(p) >= fill_count) fill_count = int'(p) + 1;
      end else if (mode == MODE_REMOVE && int'(p) < fill_count) begin
         fill_count--;
         last = fill_count;
         if (int'(p) < last) written[p] = written[last];
         written[last] = 1'b1;
      end
   endtask

   function automatic key_type random_key();
      return {$urandom(), $urandom()};
   endfunction

   // remove only where both the target and the last entry were written; else send an out-of-range remove or a lookup
   task automatic send_remove();
      int p;
      for (int tries = 0; tries < 8; tries++) begin
         if (fill_count > 0) begin
            p = $urandom_range(fill_count - 1);
            if (written[p] && written[fill_count - 1]) begin
               send_beat(MODE_REMOVE, random_key(), pos_type'(p));
               return;
            end
         end
      end
      if (fill_count < ENTRIES)
         send_beat(MODE_REMOVE, random_key(), pos_type'($urandom_range(ENTRIES - 1, fill_count)));
      else
         send_beat(MODE_LOOKUP, recent_keys[$urandom_range(63)], '0);
   endtask

   task automatic send_insert();
      int r;
      int p;
      r = $urandom_range(99);
      if (fill_count == 0 || (r < 85 && fill_count < ENTRIES)) p = fill_count;
      else if (r < 95 || fill_count >= ENTRIES - 4) p = $urandom_range(fill_count - 1);
      else p = fill_count + $urandom_range(3);
      send_beat(MODE_INSERT, random_key(), pos_type'(p));
   endtask

   initial begin
      int r;
      for (int i = 0; i < ENTRIES; i++) written[i] = 1'b0;
      for (int i = 0; i < 64; i++) recent_keys[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme keys, every mode, gaps, moves and vacated entries
      send_beat(MODE_LOOKUP, '0, '0);
      send_beat(MODE_REMOVE, '1, 8'hff);
      send_beat(MODE_INSERT, '0, 8'd0);
      send_beat(MODE_INSERT, '1, 8'd1);
      send_beat(MODE_LOOKUP, '0, '0);
      send_beat(MODE_LOOKUP, '1, '0);
      send_beat(MODE_LOOKUP, 64'h0123_4567_89ab_cdef, '0);
      send_beat(2'd3, '1, 8'hff);
      send_beat(MODE_INSERT, 64'h8000_0000_0000_0001, 8'd3);
      send_beat(MODE_INSERT, 64'h5555_aaaa_5555_aaaa, 8'd2);
      send_beat(MODE_INSERT, 64'h5555_aaaa_5555_aaaa, 8'd1);
      send_beat(MODE_LOOKUP, 64'h5555_aaaa_5555_aaaa, '0);
      send_beat(MODE_REMOVE, '0, 8'd0);
      send_beat(MODE_LOOKUP, 64'h8000_0000_0000_0001, '0);
      send_beat(MODE_LOOKUP, '0, '0);
      send_beat(MODE_REMOVE, '0, 8'd2);
      send_beat(MODE_REMOVE, '0, 8'd9);
      send_beat(MODE_LOOKUP, '1, '0);
      send_beat(MODE_INSERT, '1, 8'd3);
      send_beat(MODE_LOOKUP, '1, '0);

      for (int n = 0; n < 700; n++) begin
         steady = (n >= 300 && n < 500);
         r = $urandom_range(99);
         if (r < 38) send_insert();
         else if (r < 70) send_remove();
         else if (r < 88) send_beat(MODE_LOOKUP, recent_keys[$urandom_range(63)], '0);
         else if (r < 97) send_beat(MODE_LOOKUP, random_key(), pos_type'($urandom()));
         else send_beat(2'd3, random_key(), pos_type'($urandom()));
      end
      steady = 1'b0;

      // overwrite below the count until the map has no free slot left
      for (int n = 0; n < MAP_SLOTS + 24; n++) begin
         if (fill_count == 0) send_beat(MODE_INSERT, random_key(), '0);
         else send_beat(MODE_INSERT, random_key(), pos_type'($urandom_range(fill_count - 1)));
      end
      for (int n = 0; n < 6; n++) begin
         send_beat(MODE_LOOKUP, recent_keys[$urandom_range(63)], '0);
         send_beat(MODE_LOOKUP, random_key(), '0);
         send_remove();
         send_insert();
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[hashed_key_index_table_unit.f]
rtl/hkit_pkg.sv
rtl/hkit_ram.sv
rtl/hkit_hash.sv
rtl/hashed_key_index_table_unit.sv
tb/hkit_checker.sv
tb/testbench.sv
